// File: src/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg: shared types and constants for the biquad cascade
// Widths, register indexes, term codes and control structs used by the
// sequencer, the shared multiply-accumulate unit and the history store.
// ----------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

  localparam int MAX_STAGES_DEF = 4;
  localparam int COEF_FRAC_DEF  = 16;
  localparam int HIST_FRAC      = 8;

  localparam int SAMPLE_W   = 16;
  localparam int HIST_W     = 32;
  localparam int COEF_W     = 19;
  localparam int STAGE_W    = 3;
  localparam int PROD_W     = COEF_W + HIST_W;
  localparam int ACC_W      = 56;
  localparam int CFG_ADDR_W = 3;
  localparam int NUM_TERMS  = 5;
  localparam int TERM_W     = 3;

  localparam longint SAMP_MAX = 32767;
  localparam longint SAMP_MIN = -32768;
  localparam longint HIST_MAX = (64'sd1 <<< (HIST_W - 1)) - 64'sd1;
  localparam longint HIST_MIN = -(64'sd1 <<< (HIST_W - 1));

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A1 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A2 = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_STAGES  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BYPASS  = 3'd6;

  // product terms of one section, in issue order
  localparam logic [TERM_W-1:0] TERM_B0  = 3'd0;
  localparam logic [TERM_W-1:0] TERM_B1  = 3'd1;
  localparam logic [TERM_W-1:0] TERM_B2  = 3'd2;
  localparam logic [TERM_W-1:0] TERM_A1  = 3'd3;
  localparam logic [TERM_W-1:0] TERM_A2  = 3'd4;
  localparam logic [TERM_W-1:0] TERM_END = 3'd5;

  typedef struct packed {
    logic issue;   // load product register
    logic acc_en;  // add product into accumulator
    logic first;   // accumulator starts from this product
    logic fb;      // feedback term: subtract, no history scaling
    logic rnd_en;  // register rounded outputs
  } mac_ctrl_t;

  typedef struct packed {
    logic                       en;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [HIST_W-1:0]   y;
  } hist_wr_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [HIST_W-1:0]   y1;
    logic signed [HIST_W-1:0]   y2;
  } hist_rd_t;

endpackage

`default_nettype wire

// File: src/biq_mac.sv
// ----------------------------------------------------------------------------
// biq_mac: shared multiply-accumulate with round and saturate
// One 19x32 multiplier, registered, feeding a wide accumulator. Final sum is
// rounded half-to-even to Q24.8 history and to an integer sample.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_mac #(
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_DEF
) (
  input  wire logic                                clk,
  input  wire biq_pkg::mac_ctrl_t                  ctrl,
  input  wire logic signed [biq_pkg::COEF_W-1:0]   coef,
  input  wire logic signed [biq_pkg::HIST_W-1:0]   opnd,
  output logic signed [biq_pkg::HIST_W-1:0]        y_hist,
  output logic signed [biq_pkg::SAMPLE_W-1:0]      y_samp
);

  localparam int ACC_W = biq_pkg::ACC_W;
  localparam int SH_H  = COEF_FRAC_BITS;
  localparam int SH_S  = COEF_FRAC_BITS + biq_pkg::HIST_FRAC;

  logic signed [biq_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] term_val;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] qh, qs, rh, rs;
  logic inc_h, inc_s;

  always_comb begin
    prod_ext = ACC_W'(prod);
    term_val = ctrl.fb ? prod_ext : (prod_ext <<< biq_pkg::HIST_FRAC);
    if (ctrl.first) begin
      acc_next = ctrl.fb ? -term_val : term_val;
    end else begin
      acc_next = ctrl.fb ? (acc - term_val) : (acc + term_val);
    end
  end

  // floor shift, then bump on more than half or exact half with odd quotient
  always_comb begin
    qh    = acc >>> SH_H;
    qs    = acc >>> SH_S;
    inc_h = acc[SH_H-1] && ((|acc[SH_H-2:0]) || qh[0]);
    inc_s = acc[SH_S-1] && ((|acc[SH_S-2:0]) || qs[0]);
    rh    = qh + $signed({{(ACC_W-1){1'b0}}, inc_h});
    rs    = qs + $signed({{(ACC_W-1){1'b0}}, inc_s});
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod <= coef * opnd;
    end
    if (ctrl.acc_en) begin
      acc <= acc_next;
    end
    if (ctrl.rnd_en) begin
      if (rh > ACC_W'(biq_pkg::HIST_MAX)) begin
        y_hist <= biq_pkg::HIST_W'(biq_pkg::HIST_MAX);
      end else if (rh < ACC_W'(biq_pkg::HIST_MIN)) begin
        y_hist <= biq_pkg::HIST_W'(biq_pkg::HIST_MIN);
      end else begin
        y_hist <= rh[biq_pkg::HIST_W-1:0];
      end
      if (rs > ACC_W'(biq_pkg::SAMP_MAX)) begin
        y_samp <= biq_pkg::SAMPLE_W'(biq_pkg::SAMP_MAX);
      end else if (rs < ACC_W'(biq_pkg::SAMP_MIN)) begin
        y_samp <= biq_pkg::SAMPLE_W'(biq_pkg::SAMP_MIN);
      end else begin
        y_samp <= rs[biq_pkg::SAMPLE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: src/biq_hist.sv
// ----------------------------------------------------------------------------
// biq_hist: per-section filter history
// x1/x2/y1/y2 per section, one section read and written at a time.
// Cleared by reset and by the start-of-block flag.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_hist #(
  parameter int MAX_STAGES = biq_pkg::MAX_STAGES_DEF,
  localparam int SEC_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clr,
  input  wire logic [SEC_W-1:0]  sec,
  input  wire biq_pkg::hist_wr_t wr,
  output biq_pkg::hist_rd_t      rd
);

  logic signed [biq_pkg::SAMPLE_W-1:0] x1_mem [MAX_STAGES];
  logic signed [biq_pkg::SAMPLE_W-1:0] x2_mem [MAX_STAGES];
  logic signed [biq_pkg::HIST_W-1:0]   y1_mem [MAX_STAGES];
  logic signed [biq_pkg::HIST_W-1:0]   y2_mem [MAX_STAGES];

  always_comb begin
    rd.x1 = x1_mem[sec];
    rd.x2 = x2_mem[sec];
    rd.y1 = y1_mem[sec];
    rd.y2 = y2_mem[sec];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < MAX_STAGES; i++) begin
        x1_mem[i] <= '0;
        x2_mem[i] <= '0;
        y1_mem[i] <= '0;
        y2_mem[i] <= '0;
      end
    end else if (wr.en) begin
      x2_mem[sec] <= x1_mem[sec];
      x1_mem[sec] <= wr.x;
      y2_mem[sec] <= y1_mem[sec];
      y1_mem[sec] <= wr.y;
    end
  end

endmodule

`default_nettype wire

// File: src/biquad_cascade_lowpass_unit.sv
// Samples are processed one at a time through N sections, N = sections in use
//   (stages_in_use clamped to 1..MAX_STAGES); bypass skips the sections.
// A new sample is taken only while the sequencer is idle; each section needs five
//   passes through the single shared multiplier plus a round and a history update.
// Reset (rst, synchronous): sequencer idle, output empty, history zeroed,
//   registers at b0 = 1.0, others 0, one section, bypass off.
// ----------------------------------------------------------------------------
// biquad_cascade_lowpass_unit: cascaded DF1 biquad, one shared MAC
// Sequencer steps a section index and a term counter through the shared
// multiply-accumulate unit; history lives in a per-section store.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_lowpass_unit #(
  parameter int MAX_STAGES     = biq_pkg::MAX_STAGES_DEF,
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config write port
  input  wire logic                              cfg_we,
  input  wire logic [biq_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [biq_pkg::COEF_W-1:0]        cfg_data,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [biq_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] sample_in
  input  wire logic                              s_tuser,   // [0] start_of_block
  // output stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [biq_pkg::SAMPLE_W-1:0]           m_tdata    // [15:0] sample_out
);

  localparam int SEC_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int TERM_W = biq_pkg::TERM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,   // issue five products, accumulate one behind
    ST_RND,   // round and saturate the section sum
    ST_UPD,   // write section history, pass sample on
    ST_DONE   // hand result to the output register
  } state_t;

  state_t state;

  // config registers
  logic signed [biq_pkg::COEF_W-1:0] coef [biq_pkg::NUM_TERMS];
  logic [biq_pkg::STAGE_W-1:0]       stages_in_use;
  logic                              bypass;

  // sequencer
  logic [TERM_W-1:0]                 term;
  logic [SEC_W-1:0]                  sec;
  logic [SEC_W-1:0]                  last_sec;
  logic [SEC_W-1:0]                  last_sec_next;
  logic signed [biq_pkg::SAMPLE_W-1:0] x_cur;

  logic                              accept;
  biq_pkg::mac_ctrl_t                mac_ctrl;
  biq_pkg::hist_wr_t                 hist_wr;
  biq_pkg::hist_rd_t                 hist_rd;
  logic signed [biq_pkg::COEF_W-1:0] mac_coef;
  logic signed [biq_pkg::HIST_W-1:0] mac_opnd;
  logic signed [biq_pkg::HIST_W-1:0] y_hist;
  logic signed [biq_pkg::SAMPLE_W-1:0] y_samp;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // section count: zero acts as one, anything above the build limit clamps
  always_comb begin
    int n_eff;
    n_eff = int'(stages_in_use);
    if (n_eff < 1) begin
      n_eff = 1;
    end
    if (n_eff > MAX_STAGES) begin
      n_eff = MAX_STAGES;
    end
    last_sec_next = SEC_W'(n_eff - 1);
  end

  // ---- config writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0]       <= biq_pkg::COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
      coef[1]       <= '0;
      coef[2]       <= '0;
      coef[3]       <= '0;
      coef[4]       <= '0;
      stages_in_use <= biq_pkg::STAGE_W'(1);
      bypass        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        biq_pkg::REG_COEF_B0: coef[0] <= cfg_data;
        biq_pkg::REG_COEF_B1: coef[1] <= cfg_data;
        biq_pkg::REG_COEF_B2: coef[2] <= cfg_data;
        biq_pkg::REG_COEF_A1: coef[3] <= cfg_data;
        biq_pkg::REG_COEF_A2: coef[4] <= cfg_data;
        biq_pkg::REG_STAGES:  stages_in_use <= cfg_data[biq_pkg::STAGE_W-1:0];
        biq_pkg::REG_BYPASS:  bypass <= cfg_data[0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---- operand select for the shared multiplier ----
  always_comb begin
    unique case (term)
      biq_pkg::TERM_B0: begin
        mac_coef = coef[0];
        mac_opnd = biq_pkg::HIST_W'(x_cur);
      end
      biq_pkg::TERM_B1: begin
        mac_coef = coef[1];
        mac_opnd = biq_pkg::HIST_W'(hist_rd.x1);
      end
      biq_pkg::TERM_B2: begin
        mac_coef = coef[2];
        mac_opnd = biq_pkg::HIST_W'(hist_rd.x2);
      end
      biq_pkg::TERM_A1: begin
        mac_coef = coef[3];
        mac_opnd = hist_rd.y1;
      end
      biq_pkg::TERM_A2: begin
        mac_coef = coef[4];
        mac_opnd = hist_rd.y2;
      end
      default: begin
        mac_coef = '0;
        mac_opnd = '0;
      end
    endcase
  end

  // product of term t is registered and lands in the next cycle, so accumulation trails issue;
  // feedback products are those from a1 and a2
  always_comb begin
    mac_ctrl.issue  = (state == ST_RUN) && (term != biq_pkg::TERM_END);
    mac_ctrl.acc_en = (state == ST_RUN) && (term != biq_pkg::TERM_B0);
    mac_ctrl.first  = (term == biq_pkg::TERM_B1);
    mac_ctrl.fb     = (term == biq_pkg::TERM_A2) || (term == biq_pkg::TERM_END);
    mac_ctrl.rnd_en = (state == ST_RND);
  end

  assign hist_wr.en = (state == ST_UPD);
  assign hist_wr.x  = x_cur;
  assign hist_wr.y  = y_hist;

  // ---- sequencer and output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      term     <= biq_pkg::TERM_B0;
      sec      <= '0;
      last_sec <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // ST_DONE reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            x_cur    <= s_tdata;
            sec      <= '0;
            term     <= biq_pkg::TERM_B0;
            last_sec <= last_sec_next;
            state    <= bypass ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (term == biq_pkg::TERM_END) begin
            state <= ST_RND;
          end else begin
            term <= term + TERM_W'(1);
          end
        end
        ST_RND: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          x_cur <= y_samp;
          term  <= biq_pkg::TERM_B0;
          if (sec == last_sec) begin
            state <= ST_DONE;
          end else begin
            sec   <= sec + SEC_W'(1);
            state <= ST_RUN;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= x_cur;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  biq_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .coef   (mac_coef),
    .opnd   (mac_opnd),
    .y_hist (y_hist),
    .y_samp (y_samp)
  );

  // start of block wipes every section, bypassed or not
  biq_hist #(
    .MAX_STAGES (MAX_STAGES)
  ) u_hist (
    .clk (clk),
    .rst (rst),
    .clr (accept && s_tuser),
    .sec (sec),
    .wr  (hist_wr),
    .rd  (hist_rd)
  );

endmodule

`default_nettype wire

// File: src/biq_checker.sv
// ----------------------------------------------------------------------------
// biq_checker: port-level checks for the biquad cascade
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [biq_pkg::SAMPLE_W-1:0] m_tdata
);

  // after reset: ready for input, nothing pending on the output
  a_reset_state: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("bad state after reset");

  // one word in flight: input side closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is in flight");

  a_out_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("output valid dropped under stall");

  a_out_data_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("output word changed under stall");

endmodule

bind biquad_cascade_lowpass_unit biq_checker u_biq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
